// File: rtl/core/fixed_block_pool_allocator_core_assert.svh
// assertion macros for the block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define FBPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fbpa assertion failed");
`define FBPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa implication failed");
`else
`define FBPA_ASSERT(lbl, clk, rst_n, prop)
`define FBPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/fbpa_pkg.sv
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_W         = 32;
    localparam int COUNT_W        = 7;
    localparam int SIZE_W         = 16;
    localparam int ESIZE_W        = SIZE_W + 2;
    localparam int CFG_IDX_W      = 2;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_REINIT = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_UNKNOWN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] block_address;
    } out_item_t;

    typedef struct packed {
        logic               ready;
        logic [ESIZE_W-1:0] esize;
        logic [ADDR_W-1:0]  base;
    } pool_cfg_t;

endpackage

// File: rtl/core/fbpa_ram.sv
module fbpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/fbpa_cfg.sv
module fbpa_cfg #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_data,
    output fbpa_pkg::pool_cfg_t                cfg,
    output logic [CNT_W-1:0]                   active_n
);
    import fbpa_pkg::*;

    logic                enable_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [31:0]         count_clip;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            count_reg  <= '0;
            size_reg   <= '0;
            base_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                REG_SIZE:   size_reg   <= cfg_data[SIZE_W-1:0];
                REG_BASE:   base_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // counts above the built pool size use the whole pool
    assign count_clip = ({{(32-COUNT_W){1'b0}}, count_reg} > 32'(MAX_BLOCKS))
                        ? 32'(MAX_BLOCKS) : {{(32-COUNT_W){1'b0}}, count_reg};
    assign active_n   = count_clip[CNT_W-1:0];

    assign cfg.ready = enable_reg && (count_reg != '0) && (size_reg != '0);
    assign cfg.esize = ({2'b00, size_reg} + ESIZE_W'(3)) & ~ESIZE_W'(3);
    assign cfg.base  = base_reg;

endmodule

// File: rtl/core/fbpa_seq.sv
`include "fixed_block_pool_allocator_core_assert.svh"

module fbpa_seq #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
    parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  fbpa_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fbpa_pkg::out_item_t   out_item,
    input  fbpa_pkg::pool_cfg_t   cfg,
    input  logic [CNT_W-1:0]      active_n
);
    import fbpa_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic              reply_reg, reply_next;
    logic [1:0]        mode_reg, mode_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] run_addr_reg, run_addr_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [ADDR_W-1:0] chk_addr_reg, chk_addr_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [0:0]        ram_wdata;
    logic [0:0]        ram_rdata;
    logic              hit;

    fbpa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS),
        .AW    (IDX_W)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // flag read last cycle lines up with the address computed for it
    assign hit = chk_valid_reg && ((mode_reg == MODE_ALLOC) ? !ram_rdata[0]
                 : (ram_rdata[0] && (chk_addr_reg == addr_reg)));

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        reply_next      = reply_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        run_addr_next   = run_addr_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        chk_addr_next   = chk_addr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_item_next   = out_item_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_idx_reg;
        ram_wdata       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    clr_idx_next = '0;
                    state_next   = reply_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = in_item.mode;
                    addr_next       = in_item.address;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    idx_next        = '0;
                    run_addr_next   = cfg.base;
                    chk_valid_next  = 1'b0;
                    if (!cfg.ready)
                    begin
                        res_status_next = ST_NOT_READY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        case (in_item.mode)
                            MODE_ALLOC,
                            MODE_FREE:   state_next = S_SCAN;
                            MODE_REINIT:
                            begin
                                reply_next = 1'b1;
                                state_next = S_CLEAR;
                            end
                            default:     state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                chk_valid_next = 1'b0;
                if (idx_reg < active_n)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg[IDX_W-1:0];
                    chk_addr_next  = run_addr_reg;
                    run_addr_next  = run_addr_reg + ADDR_W'(cfg.esize);
                    idx_next       = idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = chk_idx_reg;
                    ram_wdata       = (mode_reg == MODE_ALLOC);
                    res_status_next = ST_OK;
                    res_addr_next   = (mode_reg == MODE_ALLOC) ? chk_addr_reg : '0;
                    state_next      = S_DONE;
                end
                else if (!chk_valid_reg && (idx_reg >= active_n))
                begin
                    res_status_next = (mode_reg == MODE_ALLOC) ? ST_FULL : ST_UNKNOWN;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.status        = res_status_reg;
                    out_item_next.block_address = res_addr_reg;
                    reply_next                 = 1'b0;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            reply_reg     <= 1'b0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            reply_reg     <= reply_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        run_addr_reg   <= run_addr_next;
        chk_idx_reg    <= chk_idx_next;
        chk_addr_reg   <= chk_addr_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_item_reg   <= out_item_next;
    end

    `FBPA_ASSERT_IMPL(a_we_when_busy, clk, rst_n, ram_we,
                      (state_reg == S_SCAN) || (state_reg == S_CLEAR))
    `FBPA_ASSERT_IMPL(a_out_from_done, clk, rst_n, $rose(out_valid_reg),
                      $past(state_reg) == S_DONE)
    `FBPA_ASSERT_IMPL(a_addr_zero_on_fail, clk, rst_n,
                      out_valid_reg && (out_item_reg.status != ST_OK),
                      out_item_reg.block_address == '0)
    `FBPA_ASSERT_IMPL(a_scan_bound, clk, rst_n, state_reg == S_SCAN,
                      idx_reg <= active_n)

endmodule

// File: rtl/core/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator: one used flag per block, held in a 1-bit RAM and walked
// one entry per cycle through its single read port while one adder steps the block address
// by the rounded block size. An allocate or free scans up to the n active blocks and stops
// early when it finds its block; reinitialize, like the clearing pass after reset, sweeps
// all MAX_BLOCKS flags at one per cycle, and in_stall stays high during the clearing pass
// after reset. A request made while the pool is not ready, or an unused mode, goes straight
// to its result. The next item can be accepted in the cycle after its result is loaded,
// later while out_stall holds an earlier result in the output register. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
module fixed_block_pool_allocator_core #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  fbpa_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output fbpa_pkg::out_item_t            out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);
    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    pool_cfg_t        cfg;
    logic [CNT_W-1:0] active_n;

    fbpa_cfg #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .CNT_W      (CNT_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .active_n  (active_n)
    );

    fbpa_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg       (cfg),
        .active_n  (active_n)
    );

endmodule
